// File: rtl/scl_pkg.sv
// Shared types, codes and helpers for the spliced CIGAR lift block.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps
`default_nettype none

package scl_pkg;

    // Default number of splice-site table entries
    localparam int unsigned MaxSitesDefault = 16;

    localparam int unsigned PosW = 32;
    localparam int unsigned LenW = 28;
    localparam int unsigned CodeW = 4;
    localparam int unsigned KindW = 2;
    localparam int unsigned StatW = 2;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_CIGAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // CIGAR element codes
    localparam logic [CodeW-1:0] CIG_M = 4'd0;
    localparam logic [CodeW-1:0] CIG_I = 4'd1;
    localparam logic [CodeW-1:0] CIG_D = 4'd2;
    localparam logic [CodeW-1:0] CIG_N = 4'd3;
    localparam logic [CodeW-1:0] CIG_S = 4'd4;
    localparam logic [CodeW-1:0] CIG_H = 4'd5;
    localparam logic [CodeW-1:0] CIG_P = 4'd6;
    localparam logic [CodeW-1:0] CIG_EQ = 4'd7;
    localparam logic [CodeW-1:0] CIG_X = 4'd8;

    // Result word kinds
    localparam logic [KindW-1:0] KIND_START = 2'd0;
    localparam logic [KindW-1:0] KIND_CIGAR = 2'd1;
    localparam logic [KindW-1:0] KIND_END = 2'd2;

    // End status codes
    localparam logic [StatW-1:0] ST_OK = 2'd0;
    localparam logic [StatW-1:0] ST_MISMATCH = 2'd1;
    localparam logic [StatW-1:0] ST_BAD_OP = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TSTART = 1'b0;
    localparam logic CFG_SCOUNT = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_BEGIN,
        S_SITE_A,
        S_SITE_B,
        S_TAIL,
        S_DN_SCAN,
        S_DN_PUSH,
        S_PUSH1,
        S_FIN,
        S_STATUS,
        S_DRAIN
    } state_t;

    // One splice-site table entry as read by the sequencer
    typedef struct packed {
        logic [PosW-1:0] pos;
        logic [LenW-1:0] ilen;
    } site_t;

    // One result word
    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [PosW-1:0]  gstart;
        logic [CodeW-1:0] code;
        logic [LenW-1:0]  len;
        logic [StatW-1:0] status;
    } res_t;

    // Saturate a 29-bit sum to the element length range
    function automatic logic [LenW-1:0] sat_len29(input logic [LenW:0] v);
        sat_len29 = v[LenW] ? {LenW{1'b1}} : v[LenW-1:0];
    endfunction

    // Saturate a 33-bit value to the element length range
    function automatic logic [LenW-1:0] sat_len33(input logic [PosW:0] v);
        sat_len33 = (|v[PosW:LenW]) ? {LenW{1'b1}} : v[LenW-1:0];
    endfunction

    // Saturate a 33-bit value to the position range
    function automatic logic [PosW-1:0] sat_pos33(input logic [PosW:0] v);
        sat_pos33 = v[PosW] ? {PosW{1'b1}} : v[PosW-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/scl_sites.sv
// Splice-site table: positions and intron lengths, one write and one read port.
// Depends on scl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scl_sites #(
    parameter int unsigned MAX_SITES = scl_pkg::MaxSitesDefault,
    localparam int unsigned IW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [IW-1:0]            wr_idx,
    input  wire logic [scl_pkg::PosW-1:0] wr_pos,
    input  wire logic [scl_pkg::LenW-1:0] wr_ilen,
    input  wire logic [IW-1:0]            rd_idx,
    output scl_pkg::site_t                rd_site
);

    scl_pkg::site_t entry_reg [MAX_SITES];

    // Table write; entries hold no reset value
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_idx] <= '{pos: wr_pos, ilen: wr_ilen};
        end
    end

    // Read at the sequencer's walk index
    assign rd_site = entry_reg[rd_idx];

endmodule

`default_nettype wire

// File: rtl/scl_core.sv
// Sequencer and shared adder/compare unit that walks the splice table per item,
// with the merge buffer, a one-word hold stage and the output register. Uses scl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scl_core #(
    parameter int unsigned MAX_SITES = scl_pkg::MaxSitesDefault,
    localparam int unsigned IW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1,
    localparam int unsigned CW = $clog2(MAX_SITES + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                op,
    input  wire logic [scl_pkg::PosW-1:0]  align_start,
    input  wire logic [scl_pkg::PosW-1:0]  read_length,
    input  wire logic [scl_pkg::CodeW-1:0] cigar_code,
    input  wire logic [scl_pkg::LenW-1:0]  cigar_length,
    input  wire logic                      last,
    input  wire logic [scl_pkg::PosW-1:0]  tstart,
    input  wire logic [4:0]                scount,
    output logic [IW-1:0]                  rd_idx,
    input  wire scl_pkg::site_t            rd_site,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output scl_pkg::res_t                  out_res,
    output logic                           out_eor
);

    localparam int unsigned PW = scl_pkg::PosW;
    localparam int unsigned LW = scl_pkg::LenW;
    localparam int unsigned AW = PW + 3;

    scl_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [PW:0]     cut_reg, cut_next;
    logic [PW:0]     end_reg, end_next;
    logic [AW-1:0]   acc_reg, acc_next;
    logic            spans_reg, spans_next;
    logic [scl_pkg::CodeW-1:0] code_reg, code_next;
    logic [LW-1:0]   len_reg, len_next;
    logic            last_reg, last_next;
    logic [PW-1:0]   tcur_reg, tcur_next;
    logic [PW-1:0]   rcur_reg, rcur_next;
    logic [PW-1:0]   exp_reg, exp_next;
    logic [scl_pkg::CodeW-1:0] pcode_reg, pcode_next;
    logic [LW-1:0]   plen_reg, plen_next;
    logic            pvalid_reg, pvalid_next;
    logic            err_reg, err_next;
    scl_pkg::res_t   hold_reg, hold_next;
    logic            hvalid_reg, hvalid_next;
    scl_pkg::res_t   out_reg, out_next;
    logic            ovalid_reg, ovalid_next;
    logic            oeor_reg, oeor_next;

    logic [CW-1:0]   nsites;
    logic            more;
    logic [PW:0]     site_pos;
    logic            hit;
    logic            out_free;
    logic            push_en;
    logic [scl_pkg::CodeW-1:0] push_code;
    logic [LW-1:0]   push_len;
    logic            push_merge;
    logic            stage_req;
    scl_pkg::res_t   stage_res;
    logic            go;
    logic [PW:0]     sum33;
    logic [PW:0]     rsum33;

    // Active sites, capped at the table depth
    assign nsites = (scount > 5'(MAX_SITES)) ? CW'(MAX_SITES) : CW'(scount);
    assign more = (idx_reg < nsites);
    assign rd_idx = idx_reg[IW-1:0];
    assign site_pos = {1'b0, rd_site.pos};
    assign hit = (site_pos >= cut_reg) && (site_pos < end_reg);
    assign out_free = !ovalid_reg || out_ready;

    assign in_ready = (state_reg == scl_pkg::S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_res = out_reg;
    assign out_eor = oeor_reg;

    // Cursor adders used when an item is taken
    assign sum33 = {1'b0, tcur_reg} + {{(PW - LW + 1){1'b0}}, cigar_length};
    assign rsum33 = {1'b0, rcur_reg} + {{(PW - LW + 1){1'b0}}, cigar_length};

    // Push operands per state and merge decision
    always_comb
    begin
        push_en = 1'b0;
        push_code = code_reg;
        push_len = len_reg;
        unique case (state_reg)
            scl_pkg::S_SITE_A:
            begin
                push_en = more && hit;
                push_len = LW'(site_pos - cut_reg);
            end
            scl_pkg::S_SITE_B:
            begin
                push_en = 1'b1;
                push_code = scl_pkg::CIG_N;
                push_len = rd_site.ilen;
            end
            scl_pkg::S_TAIL:
            begin
                push_en = 1'b1;
                push_len = LW'(end_reg - cut_reg);
            end
            scl_pkg::S_DN_PUSH:
            begin
                push_en = 1'b1;
                push_code = spans_reg ? scl_pkg::CIG_N : code_reg;
                push_len = scl_pkg::sat_len33(acc_reg[PW:0]);
            end
            scl_pkg::S_PUSH1:
            begin
                push_en = 1'b1;
            end
            default:
            begin
                push_en = 1'b0;
            end
        endcase
        push_merge = pvalid_reg && (pcode_reg == push_code);
    end

    // Word handed to the hold stage in this cycle, if any
    always_comb
    begin
        stage_req = 1'b0;
        stage_res = '{kind: scl_pkg::KIND_CIGAR, gstart: '0, code: pcode_reg,
                      len: plen_reg, status: scl_pkg::ST_OK};
        if (push_en && (push_len != '0) && !push_merge && pvalid_reg)
        begin
            stage_req = 1'b1;
        end
        else if (state_reg == scl_pkg::S_BEGIN && !more)
        begin
            stage_req = 1'b1;
            stage_res.kind = scl_pkg::KIND_START;
            stage_res.code = '0;
            stage_res.len = '0;
            stage_res.gstart = (|acc_reg[AW-1:PW]) ? {PW{1'b1}} : acc_reg[PW-1:0];
        end
        else if (state_reg == scl_pkg::S_FIN && last_reg && pvalid_reg)
        begin
            stage_req = 1'b1;
        end
        else if (state_reg == scl_pkg::S_STATUS)
        begin
            stage_req = 1'b1;
            stage_res.kind = scl_pkg::KIND_END;
            stage_res.code = '0;
            stage_res.len = '0;
            if (err_reg)
            begin
                stage_res.status = scl_pkg::ST_BAD_OP;
            end
            else if (rcur_reg != exp_reg)
            begin
                stage_res.status = scl_pkg::ST_MISMATCH;
            end
        end
        go = !(stage_req && hvalid_reg && !out_free);
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        cut_next = cut_reg;
        end_next = end_reg;
        acc_next = acc_reg;
        spans_next = spans_reg;
        code_next = code_reg;
        len_next = len_reg;
        last_next = last_reg;
        tcur_next = tcur_reg;
        rcur_next = rcur_reg;
        exp_next = exp_reg;
        pcode_next = pcode_reg;
        plen_next = plen_reg;
        pvalid_next = pvalid_reg;
        err_next = err_reg;
        hold_next = hold_reg;
        hvalid_next = hvalid_reg;
        out_next = out_reg;
        ovalid_next = ovalid_reg && !out_ready;
        oeor_next = oeor_reg;

        // Hold stage and output register movement
        if (stage_req && go)
        begin
            if (hvalid_reg)
            begin
                out_next = hold_reg;
                ovalid_next = 1'b1;
                oeor_next = 1'b0;
            end
            hold_next = stage_res;
            hvalid_next = 1'b1;
        end
        else if (state_reg == scl_pkg::S_DRAIN && hvalid_reg && out_free)
        begin
            out_next = hold_reg;
            ovalid_next = 1'b1;
            oeor_next = 1'b1;
            hvalid_next = 1'b0;
        end

        // Merge buffer update
        if (push_en && go && (push_len != '0))
        begin
            if (push_merge)
            begin
                plen_next = scl_pkg::sat_len29({1'b0, plen_reg} + {1'b0, push_len});
            end
            else
            begin
                pcode_next = push_code;
                plen_next = push_len;
                pvalid_next = 1'b1;
            end
        end

        unique case (state_reg)
            scl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    code_next = cigar_code;
                    len_next = cigar_length;
                    last_next = last;
                    idx_next = '0;
                    unique case (op)
                        scl_pkg::OP_BEGIN:
                        begin
                            acc_next = AW'({1'b0, tstart} + {1'b0, align_start});
                            cut_next = {1'b0, align_start};
                            tcur_next = align_start;
                            rcur_next = '0;
                            exp_next = read_length;
                            pvalid_next = 1'b0;
                            pcode_next = '0;
                            plen_next = '0;
                            err_next = 1'b0;
                            state_next = scl_pkg::S_BEGIN;
                        end
                        scl_pkg::OP_CIGAR:
                        begin
                            cut_next = {1'b0, tcur_reg};
                            end_next = sum33;
                            acc_next = AW'(cigar_length);
                            spans_next = 1'b0;
                            unique case (cigar_code)
                                scl_pkg::CIG_M, scl_pkg::CIG_EQ, scl_pkg::CIG_X:
                                begin
                                    tcur_next = scl_pkg::sat_pos33(sum33);
                                    rcur_next = scl_pkg::sat_pos33(rsum33);
                                    state_next = scl_pkg::S_SITE_A;
                                end
                                scl_pkg::CIG_D, scl_pkg::CIG_N:
                                begin
                                    tcur_next = scl_pkg::sat_pos33(sum33);
                                    state_next = scl_pkg::S_DN_SCAN;
                                end
                                scl_pkg::CIG_I, scl_pkg::CIG_S:
                                begin
                                    rcur_next = scl_pkg::sat_pos33(rsum33);
                                    state_next = scl_pkg::S_PUSH1;
                                end
                                scl_pkg::CIG_H, scl_pkg::CIG_P:
                                begin
                                    state_next = scl_pkg::S_PUSH1;
                                end
                                default:
                                begin
                                    err_next = 1'b1;
                                    state_next = scl_pkg::S_FIN;
                                end
                            endcase
                        end
                        default:
                        begin
                            state_next = scl_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            // Genome start: add introns whose site lies before the start
            scl_pkg::S_BEGIN:
            begin
                if (more)
                begin
                    if (site_pos < cut_reg)
                    begin
                        acc_next = acc_reg + AW'(rd_site.ilen);
                    end
                    idx_next = idx_reg + 1'b1;
                end
                else if (go)
                begin
                    state_next = scl_pkg::S_DRAIN;
                end
            end
            // Match element: cut at each site inside the span
            scl_pkg::S_SITE_A:
            begin
                if (!more)
                begin
                    state_next = scl_pkg::S_TAIL;
                end
                else if (!hit)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (go)
                begin
                    cut_next = site_pos;
                    state_next = scl_pkg::S_SITE_B;
                end
            end
            scl_pkg::S_SITE_B:
            begin
                if (go)
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = scl_pkg::S_SITE_A;
                end
            end
            scl_pkg::S_TAIL, scl_pkg::S_DN_PUSH, scl_pkg::S_PUSH1:
            begin
                if (go)
                begin
                    state_next = scl_pkg::S_FIN;
                end
            end
            // Deletion or skip: absorb spanned introns
            scl_pkg::S_DN_SCAN:
            begin
                if (more)
                begin
                    if (hit)
                    begin
                        acc_next = acc_reg + AW'(rd_site.ilen);
                        spans_next = 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = scl_pkg::S_DN_PUSH;
                end
            end
            // Flush the merge buffer on the last element
            scl_pkg::S_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = scl_pkg::S_DRAIN;
                end
                else if (go)
                begin
                    pvalid_next = 1'b0;
                    pcode_next = '0;
                    plen_next = '0;
                    state_next = scl_pkg::S_STATUS;
                end
            end
            scl_pkg::S_STATUS:
            begin
                if (go)
                begin
                    state_next = scl_pkg::S_DRAIN;
                end
            end
            // Release the held word marked as the item's final one
            scl_pkg::S_DRAIN:
            begin
                if (!hvalid_reg || out_free)
                begin
                    state_next = scl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = scl_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scl_pkg::S_IDLE;
            idx_reg <= '0;
            tcur_reg <= '0;
            rcur_reg <= '0;
            exp_reg <= '0;
            pcode_reg <= '0;
            plen_reg <= '0;
            pvalid_reg <= 1'b0;
            err_reg <= 1'b0;
            hvalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            tcur_reg <= tcur_next;
            rcur_reg <= rcur_next;
            exp_reg <= exp_next;
            pcode_reg <= pcode_next;
            plen_reg <= plen_next;
            pvalid_reg <= pvalid_next;
            err_reg <= err_next;
            hvalid_reg <= hvalid_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cut_reg <= cut_next;
        end_reg <= end_next;
        acc_reg <= acc_next;
        spans_reg <= spans_next;
        code_reg <= code_next;
        len_reg <= len_next;
        last_reg <= last_next;
        hold_reg <= hold_next;
        out_reg <= out_next;
        oeor_reg <= oeor_next;
    end

endmodule

`default_nettype wire

// File: rtl/spliced_cigar_lift_top.sv
// Top level of the spliced CIGAR lift: configuration registers, site table
// and sequencer. Depends on scl_pkg, scl_sites and scl_core.
//
//  Channel  Direction  Handshake            Word carried
//  in       input      in_valid/in_ready    op, site, begin and cigar fields
//  out      output     out_valid/out_ready  kind, genome_start, out_code, ...
//  cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load word is written straight into the table. With n active sites (site_count capped
// at the table depth), a begin word and a deletion or skip walk all n sites, a match
// element walks them and cuts once per site in its span, and an I/S/H/P element or an
// unknown op needs no walk; the last element of a read adds a word for the end status.
// Reset clears cursors, the merge buffer and the configuration; table entries
// stay undefined until loaded. A stalled output holds the sequencer where it emits a word.
`timescale 1ns / 1ps
`default_nettype none

module spliced_cigar_lift_top #(
    parameter int unsigned MAX_SITES = scl_pkg::MaxSitesDefault
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                op,
    input  wire logic [3:0]                site_index,
    input  wire logic [scl_pkg::PosW-1:0]  site_position,
    input  wire logic [scl_pkg::LenW-1:0]  intron_length,
    input  wire logic [scl_pkg::PosW-1:0]  align_start,
    input  wire logic [scl_pkg::PosW-1:0]  read_length,
    input  wire logic [scl_pkg::CodeW-1:0] cigar_code,
    input  wire logic [scl_pkg::LenW-1:0]  cigar_length,
    input  wire logic                      last,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [scl_pkg::KindW-1:0]      kind,
    output logic [scl_pkg::PosW-1:0]       genome_start,
    output logic [scl_pkg::CodeW-1:0]      out_code,
    output logic [scl_pkg::LenW-1:0]       out_length,
    output logic [scl_pkg::StatW-1:0]      status,
    output logic                           end_of_run,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic                      cfg_index,
    input  wire logic [scl_pkg::PosW-1:0]  cfg_data
);

    localparam int unsigned IW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;

    logic [scl_pkg::PosW-1:0] tstart_reg;
    logic [4:0]               scount_reg;
    logic                     load_en;
    logic [IW-1:0]            rd_idx;
    scl_pkg::site_t           rd_site;
    scl_pkg::res_t            res;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tstart_reg <= '0;
            scount_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                scl_pkg::CFG_TSTART: tstart_reg <= cfg_data;
                scl_pkg::CFG_SCOUNT: scount_reg <= cfg_data[4:0];
                default: tstart_reg <= tstart_reg;
            endcase
        end
    end

    // Table loads go straight in; slots beyond the table are dropped
    assign load_en = in_valid && in_ready && (op == scl_pkg::OP_LOAD)
                     && ({1'b0, site_index} < 5'(MAX_SITES));

    scl_sites #(
        .MAX_SITES(MAX_SITES)
    ) u_sites (
        .clk     (clk),
        .wr_en   (load_en),
        .wr_idx  (IW'(site_index)),
        .wr_pos  (site_position),
        .wr_ilen (intron_length),
        .rd_idx  (rd_idx),
        .rd_site (rd_site)
    );

    scl_core #(
        .MAX_SITES(MAX_SITES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .align_start  (align_start),
        .read_length  (read_length),
        .cigar_code   (cigar_code),
        .cigar_length (cigar_length),
        .last         (last),
        .tstart       (tstart_reg),
        .scount       (scount_reg),
        .rd_idx       (rd_idx),
        .rd_site      (rd_site),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_res      (res),
        .out_eor      (end_of_run)
    );

    assign kind = res.kind;
    assign genome_start = res.gstart;
    assign out_code = res.code;
    assign out_length = res.len;
    assign status = res.status;

endmodule

`default_nettype wire
